@@ src/text_message_receiver_assert.svh @@
// Assertion macros for the text message receiver.
// Needs nothing else; taken in by the files that carry assertions.
`ifndef TEXT_MESSAGE_RECEIVER_ASSERT_SVH
`define TEXT_MESSAGE_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define TMR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// An implication whose consequent is checked in the cycle after its antecedent.
`define TMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TMR_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/tmr_pkg.sv @@
// Shared types and constants of the text message receiver.
// Used by the top, checksum and session control modules and by the testbench.
package tmr_pkg;

  localparam int unsigned MAX_CHARS_DEF = 64;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [2:0] {
    CMD_BEGIN    = 3'd0,
    CMD_PARAM    = 3'd1,
    CMD_END      = 3'd2,
    CMD_CHAR     = 3'd3,
    CMD_CHECKSUM = 3'd4,
    CMD_TICK     = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    REPLY_READY    = 3'd0,
    REPLY_BUSY     = 3'd1,
    REPLY_WRONG    = 3'd2,
    REPLY_TIMEOUT  = 3'd3,
    REPLY_CHAR     = 3'd4
  } reply_e;

  // Commands from the session control to the checksum unit.
  typedef struct packed {
    logic add;    // fold one character into the sums
    logic first;  // the character is the first of the message
    logic clear;  // drop all sums
  } csum_cmd_t;

endpackage

@@ src/tmr_if.sv @@
// Channel interfaces of the text message receiver: frames in, replies out,
// and the configuration write channel. Depends on nothing.
interface tmr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] dest_addr;
  logic [15:0] caller_addr;
  logic        caller_valid;
  logic [15:0] char_code;
  logic [16:0] checksum_id;

  modport source (output valid, command, dest_addr, caller_addr, caller_valid,
                  char_code, checksum_id, input ready);
  modport sink (input valid, command, dest_addr, caller_addr, caller_valid,
                char_code, checksum_id, output ready);
endinterface

interface tmr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply_kind;
  logic [15:0] to_addr;
  logic [15:0] from_addr;
  logic [16:0] reply_value;
  logic [15:0] out_char;
  logic        last;

  modport source (output valid, reply_kind, to_addr, from_addr, reply_value,
                  out_char, last, input ready);
  modport sink (input valid, reply_kind, to_addr, from_addr, reply_value,
                out_char, last, output ready);
endinterface

interface tmr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/text_message_receiver.sv @@
// Text message receiver. Every frame that is transferred is processed at
// once. A frame is taken only in a cycle in which the reply register is empty
// or its reply is being transferred, so a stalled reply side holds the input.
// An end frame reads the stored characters out of the character memory
// through its single read port, one character per cycle while the reply
// side is not stalled. After its transfer the input stays blocked until
// all stored characters (at most MAX_CHARS) are loaded as replies. The timeout
// is written through the configuration channel, which is always ready.
module text_message_receiver #(
  parameter int unsigned MAX_CHARS = tmr_pkg::MAX_CHARS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmr_in_if.sink    in_i,
  tmr_out_if.source out_o,
  tmr_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  logic [15:0]        timeout_q;
  logic               mem_wr;
  logic [AW-1:0]      mem_wr_addr;
  logic [15:0]        mem_wr_data;
  logic               mem_rd;
  logic [AW-1:0]      mem_rd_addr;
  logic [15:0]        mem_rd_data;
  tmr_pkg::csum_cmd_t csum_cmd;
  logic               csum_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tmr_pkg::TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  tmr_char_mem #(
    .DEPTH (MAX_CHARS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  tmr_csum u_csum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (csum_cmd),
    .char_code_i   (in_i.char_code),
    .checksum_id_i (in_i.checksum_id),
    .match_o       (csum_match)
  );

  tmr_ctrl #(
    .MAX_CHARS (MAX_CHARS),
    .AW        (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .timeout_i     (timeout_q),
    .mem_wr_o      (mem_wr),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_o      (mem_rd),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .csum_cmd_o    (csum_cmd),
    .csum_match_i  (csum_match)
  );

endmodule

@@ src/tmr_char_mem.sv @@
// Character store of the text message receiver: one write port and one
// read port with registered read data. Depends on nothing.
module tmr_char_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [15:0]   rd_data_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read, so a stalled output can wait on it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/tmr_csum.sv @@
// Running message checksum of the text message receiver.
// Depends on tmr_pkg for the command struct.
module tmr_csum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmr_pkg::csum_cmd_t cmd_i,
  input  logic [15:0]        char_code_i,
  input  logic [16:0]        checksum_id_i,
  output logic               match_o
);

  logic [7:0] byte_count_q, byte_count_d;
  logic [7:0] byte_sum_q, byte_sum_d;
  logic [7:0] tail_q, tail_d;
  logic [7:0] weighted_q, weighted_d;
  logic [7:0] hi_byte, lo_byte;
  logic [7:0] tail_mid, weighted_mid;
  logic [15:0] checksum;

  assign hi_byte = char_code_i[15:8];
  assign lo_byte = char_code_i[7:0];

  // The high byte of the first character carries no weight.
  assign tail_mid     = cmd_i.first ? tail_q : 8'(tail_q + hi_byte);
  assign weighted_mid = cmd_i.first ? weighted_q : 8'(weighted_q + tail_mid);

  always_comb begin
    byte_count_d = byte_count_q;
    byte_sum_d   = byte_sum_q;
    tail_d       = tail_q;
    weighted_d   = weighted_q;
    if (cmd_i.clear) begin
      byte_count_d = '0;
      byte_sum_d   = '0;
      tail_d       = '0;
      weighted_d   = '0;
    end else if (cmd_i.add) begin
      byte_count_d = 8'(byte_count_q + 8'd2);
      byte_sum_d   = 8'(byte_sum_q + hi_byte + lo_byte);
      tail_d       = 8'(tail_mid + lo_byte);
      weighted_d   = 8'(weighted_mid + tail_mid + lo_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      byte_sum_q   <= '0;
      tail_q       <= '0;
      weighted_q   <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      byte_sum_q   <= byte_sum_d;
      tail_q       <= tail_d;
      weighted_q   <= weighted_d;
    end
  end

  assign checksum = {8'(byte_count_q + weighted_q), 8'(byte_sum_q + 8'd1)};
  assign match_o  = ({1'b0, checksum} == checksum_id_i);

endmodule

@@ src/tmr_ctrl.sv @@
// Session control of the text message receiver: frame decoding, timer,
// reply register and the read-out of the character store.
// Depends on tmr_pkg, the channel interfaces and the assertion macros.
`include "text_message_receiver_assert.svh"

module tmr_ctrl #(
  parameter int unsigned MAX_CHARS = tmr_pkg::MAX_CHARS_DEF,
  parameter int unsigned AW        = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tmr_in_if.sink             in_i,
  tmr_out_if.source          out_o,
  input  logic [15:0]        timeout_i,
  output logic               mem_wr_o,
  output logic [AW-1:0]      mem_wr_addr_o,
  output logic [15:0]        mem_wr_data_o,
  output logic               mem_rd_o,
  output logic [AW-1:0]      mem_rd_addr_o,
  input  logic [15:0]        mem_rd_data_i,
  output tmr_pkg::csum_cmd_t csum_cmd_o,
  input  logic               csum_match_i
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_e;

  localparam logic [15:0] MaxCount = 16'(MAX_CHARS);

  state_e          state_q, state_d;
  logic            open_q, open_d;
  logic [15:0]     owner_q, owner_d;
  logic [15:0]     own_q, own_d;
  logic [15:0]     count_q, count_d;
  logic [15:0]     timer_left_q, timer_left_d;
  logic            timer_run_q, timer_run_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   last_idx_q, last_idx_d;
  logic            out_valid_q, out_valid_d;
  tmr_pkg::reply_e out_kind_q, out_kind_d;
  logic [15:0]     out_to_q, out_to_d;
  logic [15:0]     out_from_q, out_from_d;
  logic [16:0]     out_value_q, out_value_d;
  logic [15:0]     out_char_q, out_char_d;
  logic            out_last_q, out_last_d;

  logic            out_free;
  logic            in_ready;
  logic            accept;
  logic            do_load;
  logic            do_clear;
  logic            do_restart;
  logic [15:0]     stored_n;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == S_IDLE) && out_free;
  assign accept   = in_i.valid && in_ready;
  assign stored_n = (count_q > MaxCount) ? MaxCount : count_q;

  always_comb begin
    state_d      = state_q;
    open_d       = open_q;
    owner_d      = owner_q;
    own_d        = own_q;
    count_d      = count_q;
    timer_left_d = timer_left_q;
    timer_run_d  = timer_run_q;
    idx_d        = idx_q;
    last_idx_d   = last_idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_kind_d   = out_kind_q;
    out_to_d     = out_to_q;
    out_from_d   = out_from_q;
    out_value_d  = out_value_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    do_load      = 1'b0;
    do_clear     = 1'b0;
    do_restart   = 1'b0;
    mem_wr_o     = 1'b0;
    mem_rd_o     = 1'b0;
    mem_rd_addr_o = idx_q;
    csum_cmd_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (tmr_pkg::cmd_e'(in_i.command) != tmr_pkg::CMD_TICK) begin
            own_d = in_i.dest_addr;
          end
          case (tmr_pkg::cmd_e'(in_i.command))
            tmr_pkg::CMD_BEGIN: begin
              if (in_i.caller_valid) begin
                do_load     = 1'b1;
                out_to_d    = in_i.caller_addr;
                out_value_d = '0;
                out_char_d  = '0;
                out_last_d  = 1'b1;
                if (!open_q) begin
                  out_kind_d = tmr_pkg::REPLY_READY;
                  open_d     = 1'b1;
                  owner_d    = in_i.caller_addr;
                  do_restart = 1'b1;
                end else begin
                  out_kind_d = tmr_pkg::REPLY_BUSY;
                end
              end
            end
            tmr_pkg::CMD_PARAM: begin
              do_restart = 1'b1;
            end
            tmr_pkg::CMD_END: begin
              // The first read goes out with the transfer of the end frame.
              if (count_q != '0) begin
                state_d       = S_STREAM;
                mem_rd_o      = 1'b1;
                mem_rd_addr_o = '0;
                idx_d         = '0;
                last_idx_d    = AW'(stored_n - 16'd1);
              end
            end
            tmr_pkg::CMD_CHAR: begin
              mem_wr_o         = (count_q < MaxCount);
              csum_cmd_o.add   = 1'b1;
              csum_cmd_o.first = (count_q == '0);
              if (count_q != 16'hFFFF) begin
                count_d = count_q + 16'd1;
              end
              do_restart = 1'b1;
            end
            tmr_pkg::CMD_CHECKSUM: begin
              if (!csum_match_i) begin
                do_load     = 1'b1;
                do_clear    = 1'b1;
                out_kind_d  = tmr_pkg::REPLY_WRONG;
                out_to_d    = owner_q;
                out_value_d = in_i.checksum_id;
                out_char_d  = '0;
                out_last_d  = 1'b1;
              end else begin
                do_restart = 1'b1;
              end
            end
            tmr_pkg::CMD_TICK: begin
              if (timer_run_q) begin
                if (timer_left_q <= 16'd1) begin
                  do_load     = 1'b1;
                  do_clear    = 1'b1;
                  out_kind_d  = tmr_pkg::REPLY_TIMEOUT;
                  out_to_d    = owner_q;
                  out_value_d = {1'b0, count_q};
                  out_char_d  = '0;
                  out_last_d  = 1'b1;
                end else begin
                  timer_left_d = timer_left_q - 16'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STREAM: begin
        if (out_free) begin
          do_load     = 1'b1;
          out_kind_d  = tmr_pkg::REPLY_CHAR;
          out_to_d    = owner_q;
          out_value_d = '0;
          out_char_d  = mem_rd_data_i;
          out_last_d  = (idx_q == last_idx_q);
          if (idx_q == last_idx_q) begin
            do_clear = 1'b1;
            state_d  = S_IDLE;
          end else begin
            idx_d         = idx_q + AW'(1);
            mem_rd_o      = 1'b1;
            mem_rd_addr_o = idx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_load) begin
      out_valid_d = 1'b1;
      out_from_d  = own_d;
    end
    if (do_restart) begin
      timer_left_d = timeout_i;
      timer_run_d  = 1'b1;
    end
    if (do_clear) begin
      open_d           = 1'b0;
      owner_d          = '0;
      count_d          = '0;
      timer_left_d     = '0;
      timer_run_d      = 1'b0;
      csum_cmd_o.clear = 1'b1;
    end
  end

  assign mem_wr_addr_o = count_q[AW-1:0];
  assign mem_wr_data_o = in_i.char_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      open_q       <= 1'b0;
      owner_q      <= '0;
      own_q        <= '0;
      count_q      <= '0;
      timer_left_q <= '0;
      timer_run_q  <= 1'b0;
      idx_q        <= '0;
      last_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= tmr_pkg::REPLY_READY;
      out_to_q     <= '0;
      out_from_q   <= '0;
      out_value_q  <= '0;
      out_char_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      open_q       <= open_d;
      owner_q      <= owner_d;
      own_q        <= own_d;
      count_q      <= count_d;
      timer_left_q <= timer_left_d;
      timer_run_q  <= timer_run_d;
      idx_q        <= idx_d;
      last_idx_q   <= last_idx_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_to_q     <= out_to_d;
      out_from_q   <= out_from_d;
      out_value_q  <= out_value_d;
      out_char_q   <= out_char_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.reply_kind  = out_kind_q;
  assign out_o.to_addr     = out_to_q;
  assign out_o.from_addr   = out_from_q;
  assign out_o.reply_value = out_value_q;
  assign out_o.out_char    = out_char_q;
  assign out_o.last        = out_last_q;

  // The store is never written while it is being read out.
  `TMR_ASSERT(a_no_write_in_stream, clk_i, rst_ni,
              !(state_q == S_STREAM && mem_wr_o), "store written during read-out")
  // The read-out index stays within the stored characters.
  `TMR_ASSERT(a_idx_in_range, clk_i, rst_ni,
              !(state_q == S_STREAM && idx_q > last_idx_q), "read-out index overran")
  // An open session always has its timer running.
  `TMR_ASSERT(a_open_has_timer, clk_i, rst_ni,
              !open_q || timer_run_q, "open session without a running timer")
  // Once the final character is loaded the session is empty.
  `TMR_ASSERT_NEXT(a_stream_clears, clk_i, rst_ni,
                   state_q == S_STREAM && do_load && out_last_d,
                   count_q == '0 && !open_q && state_q == S_IDLE,
                   "session not cleared after read-out")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the text message receiver: directed table, then
// random message sessions, replies checked against table or in-bench predictor.
// Depends on tmr_pkg and the channel interfaces in tmr_if.sv.
module tb_top;
  import tmr_pkg::*;

  localparam int unsigned STORE_DEPTH     = MAX_CHARS_DEF;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned PHASE_ITEMS     = 20;
  localparam int unsigned NUM_PHASES      = 6;
  // Command codes the block decodes as unused.
  localparam logic [2:0]  CMD_SPARE_6     = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7     = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] dest_addr;
    logic [15:0] caller_addr;
    logic        caller_valid;
    logic [15:0] char_code;
    logic [16:0] checksum_id;
  } frame_t;

  typedef struct packed {
    reply_e      kind;
    logic [15:0] to_addr;
    logic [15:0] from_addr;
    logic [16:0] value;
    logic [15:0] out_char;
    logic        last;
  } reply_t;

  typedef enum logic [1:0] {
    ROW_FROM_MODEL,
    ROW_NO_REPLY,
    ROW_ONE_REPLY,
    ROW_TIMEOUT_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    frame_t      frame;
    reply_t      reply;
    logic [15:0] timeout_value;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tmr_in_if  in_ch ();
  tmr_out_if out_ch ();
  tmr_cfg_if cfg_ch ();

  text_message_receiver uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #4 clk_i = ~clk_i;

  // Predicted state of the receiver.
  logic [15:0] timeout_setting = TIMEOUT_RESET;
  bit          sess_open       = 1'b0;
  logic [15:0] sess_owner      = '0;
  logic [15:0] dev_addr        = '0;
  logic [15:0] msg_chars [STORE_DEPTH];
  logic [15:0] msg_len         = '0;
  logic [7:0]  byte_total      = '0;
  logic [7:0]  sum_bytes       = '0;
  logic [7:0]  sum_tail        = '0;
  logic [7:0]  sum_weighted    = '0;
  logic [15:0] ticks_left      = '0;
  bit          timer_on        = 1'b0;

  reply_t      reply_buf [STORE_DEPTH];
  reply_t      pending_replies [$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  bit          valid_high   = 1'b0;
  bit          hold_off_req = 1'b0;

  stim_row_t   directed_rows [$];

  function automatic reply_t reply_of(reply_e kind, logic [15:0] to, logic [15:0] from,
                                      logic [16:0] value, logic [15:0] ch, logic last);
    reply_t r;
    r.kind      = kind;
    r.to_addr   = to;
    r.from_addr = from;
    r.value     = value;
    r.out_char  = ch;
    r.last      = last;
    return r;
  endfunction

  function automatic frame_t frame_of(logic [2:0] cmd, logic [15:0] dest, logic [15:0] caller,
                                      logic cv, logic [15:0] ch, logic [16:0] id);
    frame_t f;
    f.command      = cmd;
    f.dest_addr    = dest;
    f.caller_addr  = caller;
    f.caller_valid = cv;
    f.char_code    = ch;
    f.checksum_id  = id;
    return f;
  endfunction

  function automatic frame_t random_frame(logic [2:0] cmd);
    return frame_of(cmd, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                    16'($urandom), 17'($urandom_range(0, 131071)));
  endfunction

  function automatic stim_row_t frame_row(row_kind_e kind, frame_t f, reply_t r);
    stim_row_t row;
    row.kind          = kind;
    row.frame         = f;
    row.reply         = r;
    row.timeout_value = '0;
    return row;
  endfunction

  function automatic stim_row_t timeout_row(logic [15:0] v);
    stim_row_t row;
    row               = '0;
    row.kind          = ROW_TIMEOUT_WRITE;
    row.timeout_value = v;
    return row;
  endfunction

  function automatic void end_session();
    sess_open    = 1'b0;
    sess_owner   = '0;
    msg_len      = '0;
    byte_total   = '0;
    sum_bytes    = '0;
    sum_tail     = '0;
    sum_weighted = '0;
    ticks_left   = '0;
    timer_on     = 1'b0;
  endfunction

  function automatic void restart_timer();
    ticks_left = timeout_setting;
    timer_on   = 1'b1;
  endfunction

  // Every byte but the first of the message feeds the position-weighted sum.
  function automatic void fold_byte(logic [7:0] b, bit first);
    sum_bytes = sum_bytes + b;
    if (!first) begin
      sum_tail     = sum_tail + b;
      sum_weighted = sum_weighted + sum_tail;
    end
    byte_total = byte_total + 8'd1;
  endfunction

  function automatic logic [15:0] running_checksum();
    return {8'(byte_total + sum_weighted), 8'(8'd1 + sum_bytes)};
  endfunction

  // Advances the predicted state by one frame; returns the number of replies
  // left in reply_buf.
  function automatic int receiver_replies(frame_t f);
    int n;
    bit first;
    n = 0;
    if (f.command != CMD_TICK) dev_addr = f.dest_addr;
    case (f.command)
      CMD_BEGIN: begin
        if (f.caller_valid) begin
          if (!sess_open) begin
            sess_open    = 1'b1;
            sess_owner   = f.caller_addr;
            reply_buf[0] = reply_of(REPLY_READY, sess_owner, dev_addr, '0, '0, 1'b1);
            restart_timer();
          end else begin
            reply_buf[0] = reply_of(REPLY_BUSY, f.caller_addr, dev_addr, '0, '0, 1'b1);
          end
          n = 1;
        end
      end
      CMD_PARAM: restart_timer();
      CMD_END: begin
        if (msg_len != 0) begin
          n = (msg_len > STORE_DEPTH) ? STORE_DEPTH : msg_len;
          for (int i = 0; i < n; i++)
            reply_buf[i] = reply_of(REPLY_CHAR, sess_owner, dev_addr, '0, msg_chars[i],
                                    i == n - 1);
          end_session();
        end
      end
      CMD_CHAR: begin
        first = (msg_len == 0);
        if (msg_len < STORE_DEPTH) msg_chars[msg_len] = f.char_code;
        fold_byte(f.char_code[15:8], first);
        fold_byte(f.char_code[7:0], 1'b0);
        if (msg_len != 16'hFFFF) msg_len = msg_len + 16'd1;
        restart_timer();
      end
      CMD_CHECKSUM: begin
        if ({1'b0, running_checksum()} != f.checksum_id) begin
          reply_buf[0] = reply_of(REPLY_WRONG, sess_owner, dev_addr, f.checksum_id, '0, 1'b1);
          end_session();
          n = 1;
        end else begin
          restart_timer();
        end
      end
      CMD_TICK: begin
        if (timer_on) begin
          if (ticks_left <= 1) begin
            reply_buf[0] = reply_of(REPLY_TIMEOUT, sess_owner, dev_addr, {1'b0, msg_len}, '0,
                                    1'b1);
            end_session();
            n = 1;
          end else begin
            ticks_left = ticks_left - 16'd1;
          end
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  task automatic report(input string msg);
    error_count++;
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [16:0] got, input logic [16:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Offers one frame, waits for its transfer and records what it should cause.
  task automatic send_frame(input frame_t f, input row_kind_e how, input reply_t typed);
    int n;
    int gap;
    {in_ch.command, in_ch.dest_addr, in_ch.caller_addr, in_ch.caller_valid,
     in_ch.char_code, in_ch.checksum_id} <= f;
    in_ch.valid <= 1'b1;
    valid_high = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    n = receiver_replies(f);
    case (how)
      ROW_FROM_MODEL: for (int i = 0; i < n; i++) pending_replies.push_back(reply_buf[i]);
      ROW_ONE_REPLY:  pending_replies.push_back(typed);
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      valid_high = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_random(input frame_t f);
    send_frame(f, ROW_FROM_MODEL, '0);
  endtask

  // Drops valid and waits until every predicted reply has come out.
  task automatic settle();
    if (valid_high) begin
      in_ch.valid <= 1'b0;
      valid_high = 1'b0;
    end
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle();
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    timeout_setting = v;
  endtask

  // One message exchange; mostly well formed, with broken endings mixed in.
  task automatic run_session(input int forced_len);
    int r;
    int len;
    int ticks;
    frame_t f;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_random(random_frame(3'($urandom_range(0, 7))));
    end else begin
      if ($urandom_range(0, 9) == 0) send_random(random_frame(CMD_PARAM));
      f = random_frame(CMD_BEGIN);
      f.caller_valid = ($urandom_range(0, 11) != 0);
      send_random(f);
      if ($urandom_range(0, 9) == 0) begin
        f = random_frame(CMD_BEGIN);
        f.caller_valid = 1'b1;
        send_random(f);
      end
      r = $urandom_range(0, 99);
      if (forced_len >= 0) len = forced_len;
      else if (r < 75) len = $urandom_range(0, 8);
      else if (r < 95) len = $urandom_range(9, 30);
      else len = $urandom_range(60, 70);
      for (int i = 0; i < len; i++) begin
        f = random_frame(CMD_CHAR);
        if ($urandom_range(0, 7) == 0) f.char_code = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        send_random(f);
        if ($urandom_range(0, 19) == 0) send_random(random_frame(CMD_TICK));
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        f = random_frame(CMD_CHECKSUM);
        f.checksum_id = {1'b0, running_checksum()};
        send_random(f);
        send_random(random_frame(CMD_END));
      end else if (r < 75) begin
        send_random(random_frame(CMD_CHECKSUM));
        if ($urandom_range(0, 1) == 1) send_random(random_frame(CMD_END));
      end else if (r < 85) begin
        send_random(random_frame(CMD_END));
      end else begin
        ticks = (timeout_setting < 6) ? int'(timeout_setting) + 1 : 3;
        repeat (ticks) send_random(random_frame(CMD_TICK));
        send_random(random_frame(CMD_END));
      end
    end
  endtask

  // Reply checker and run watchdog.
  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni) begin
      cycle_count++;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_replies.size() == 0) begin
          report("reply transfer with no reply pending");
        end else begin
          want = pending_replies.pop_front();
          check_field("reply_kind", out_ch.reply_kind, want.kind);
          check_field("to_addr", out_ch.to_addr, want.to_addr);
          check_field("from_addr", out_ch.from_addr, want.from_addr);
          check_field("reply_value", out_ch.reply_value, want.value);
          check_field("out_char", out_ch.out_char, want.out_char);
          check_field("last", out_ch.last, want.last);
        end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Reply side: rotating stall patterns, plus one long hold-off on request.
  initial begin : reply_sink
    int unsigned pattern_cycle;
    pattern_cycle = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        pattern_cycle++;
        case ((pattern_cycle / 40) % 4)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (pattern_cycle % 8 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [15:0] phase_timeouts [NUM_PHASES];
    int unsigned phase_start;
    in_ch.valid        = 1'b0;
    in_ch.command      = '0;
    in_ch.dest_addr    = '0;
    in_ch.caller_addr  = '0;
    in_ch.caller_valid = 1'b0;
    in_ch.char_code    = '0;
    in_ch.checksum_id  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    rst_ni             = 1'b0;
    phase_timeouts     = '{16'd1, 16'd0, 16'd3, 16'd65535, TIMEOUT_RESET, 16'd0};
    phase_timeouts[5]  = 16'($urandom_range(2, 40));

    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_SPARE_6, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 17'h1FFFF), '0));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_SPARE_7, 16'h0000, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));
    // A begin whose address part is malformed is ignored.
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_BEGIN, 16'h1234, 16'h4321, 1'b0, 16'h0000, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_END, 16'h1234, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));
    // The checksum of an empty message is 1.
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_CHECKSUM, 16'h1234, 16'h0000, 1'b0, 16'h0000, 17'd1), '0));
    directed_rows.push_back(frame_row(ROW_ONE_REPLY,
      frame_of(CMD_CHECKSUM, 16'hABCD, 16'h0000, 1'b0, 16'h0000, 17'h1FFFF),
      reply_of(REPLY_WRONG, 16'h0000, 16'hABCD, 17'h1FFFF, '0, 1'b1)));
    directed_rows.push_back(frame_row(ROW_ONE_REPLY,
      frame_of(CMD_BEGIN, 16'h0001, 16'hFFFF, 1'b1, 16'h0000, 17'h00000),
      reply_of(REPLY_READY, 16'hFFFF, 16'h0001, '0, '0, 1'b1)));
    directed_rows.push_back(frame_row(ROW_ONE_REPLY,
      frame_of(CMD_BEGIN, 16'h0002, 16'h0000, 1'b1, 16'h0000, 17'h00000),
      reply_of(REPLY_BUSY, 16'h0000, 16'h0002, '0, '0, 1'b1)));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_CHAR, 16'h0002, 16'h0000, 1'b0, 16'hFFFF, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_CHAR, 16'h0002, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_CHAR, 16'h0002, 16'h0000, 1'b0, 16'h8001, 17'h00000), '0));
    // Bytes FF FF 00 00 80 01 give a checksum of 0x0280.
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_CHECKSUM, 16'h0002, 16'h0000, 1'b0, 16'h0000, 17'h00280), '0));
    directed_rows.push_back(frame_row(ROW_FROM_MODEL,
      frame_of(CMD_END, 16'h0003, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_ONE_REPLY,
      frame_of(CMD_BEGIN, 16'hA5A5, 16'h5A5A, 1'b1, 16'h0000, 17'h00000),
      reply_of(REPLY_READY, 16'h5A5A, 16'hA5A5, '0, '0, 1'b1)));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_CHAR, 16'hA5A5, 16'h0000, 1'b0, 16'h1234, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_ONE_REPLY,
      frame_of(CMD_CHECKSUM, 16'h0F0F, 16'h0000, 1'b0, 16'h0000, 17'd99999),
      reply_of(REPLY_WRONG, 16'h5A5A, 16'h0F0F, 17'd99999, '0, 1'b1)));
    // A zero timeout expires on the first tick.
    directed_rows.push_back(timeout_row(16'd0));
    directed_rows.push_back(frame_row(ROW_NO_REPLY,
      frame_of(CMD_PARAM, 16'h3333, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_ONE_REPLY,
      frame_of(CMD_TICK, 16'h7777, 16'h0000, 1'b0, 16'h0000, 17'h00000),
      reply_of(REPLY_TIMEOUT, 16'h0000, 16'h3333, '0, '0, 1'b1)));
    directed_rows.push_back(timeout_row(16'hFFFF));
    directed_rows.push_back(frame_row(ROW_FROM_MODEL,
      frame_of(CMD_BEGIN, 16'h0101, 16'h0202, 1'b1, 16'h0000, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_FROM_MODEL,
      frame_of(CMD_CHAR, 16'h0101, 16'h0000, 1'b0, 16'h00FF, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_FROM_MODEL,
      frame_of(CMD_TICK, 16'h0000, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));
    directed_rows.push_back(frame_row(ROW_FROM_MODEL,
      frame_of(CMD_END, 16'h0101, 16'h0000, 1'b0, 16'h0000, 17'h00000), '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_TIMEOUT_WRITE)
        write_timeout(directed_rows[i].timeout_value);
      else
        send_frame(directed_rows[i].frame, directed_rows[i].kind, directed_rows[i].reply);
    end

    // The first random phase starts under a long reply hold-off so that the
    // block fills up and blocks further frames.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_timeout(phase_timeouts[p]);
      phase_start = items_sent;
      if (p == 0) hold_off_req = 1'b1;
      run_session(p == 3 ? 70 : (p == 4 ? 130 : -1));
      while (items_sent < phase_start + PHASE_ITEMS) run_session(-1);
    end

    settle();
    repeat (STORE_DEPTH) @(posedge clk_i);
    if (error_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ text_message_receiver.f @@
+incdir+src
src/tmr_pkg.sv
src/tmr_if.sv
src/tmr_char_mem.sv
src/tmr_csum.sv
src/tmr_ctrl.sv
src/text_message_receiver.sv
dv/tb_top.sv
